// ----- rtl/button_debounce_press_classifier_defines.svh -----
// ----------------------------------------------------------------------------
// Button debounce press classifier assertion macros
// Concurrent assertion helpers, sampled on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_PRESS_CLASSIFIER_DEFINES_SVH
`define BUTTON_DEBOUNCE_PRESS_CLASSIFIER_DEFINES_SVH

`ifndef SYNTHESIS
`define BDPC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bdpc: same-cycle check failed");
`define BDPC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bdpc: next-cycle check failed");
`else
`define BDPC_ASSERT_IMP(lbl, ante, cons)
`define BDPC_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/bdpc_pkg.sv -----
// ----------------------------------------------------------------------------
// Button debounce press classifier package
// Counter widths, event codes and register map.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bdpc_pkg;

  localparam int unsigned TICK_COUNTER_BITS = 16;
  localparam int unsigned THR_BITS          = 16;
  localparam int unsigned CMP_BITS          =
    (TICK_COUNTER_BITS > THR_BITS) ? TICK_COUNTER_BITS : THR_BITS;

  typedef logic [TICK_COUNTER_BITS-1:0] hold_t;
  typedef logic [THR_BITS-1:0]          thr_t;
  typedef logic [CMP_BITS-1:0]          cmp_t;

  localparam int unsigned ADDR_BITS = 5;
  typedef logic [2:0] reg_idx_t;

  localparam reg_idx_t REG_ACTIVE_LEVEL   = 3'd0;
  localparam reg_idx_t REG_ENABLE         = 3'd1;
  localparam reg_idx_t REG_DEBOUNCE_TICKS = 3'd2;
  localparam reg_idx_t REG_POLL_TICKS     = 3'd3;
  localparam reg_idx_t REG_SHORT_MAX      = 3'd4;
  localparam reg_idx_t REG_LONG_MIN       = 3'd5;
  localparam reg_idx_t REG_EXTENDED_MIN   = 3'd6;

  typedef enum logic [2:0] {
    EV_NONE         = 3'd0,
    EV_SHORT        = 3'd1,
    EV_LONG_START   = 3'd2,
    EV_LONG_RELEASE = 3'd3,
    EV_EXT_START    = 3'd4,
    EV_EXT_RELEASE  = 3'd5
  } event_t;

endpackage

// ----- rtl/button_debounce_press_classifier.sv -----
// ----------------------------------------------------------------------------
// Button debounce press classifier
// Result: held in the state and event registers, which load on item accept.
// Throughput: 1 item per cycle; the next item is taken while out_ready is high or no result is held.
// Reset: sync active low; idle, counters cleared, disabled, default thresholds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "button_debounce_press_classifier_defines.svh"

module button_debounce_press_classifier (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_pin_level,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [2:0]                     out_event_code,
  output logic                           out_pressed,
  output logic [2:0]                     out_machine_state,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bdpc_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  typedef enum logic [2:0] {
    ST_IDLE        = 3'd0,
    ST_DEB_PRESS   = 3'd1,
    ST_PRESSED     = 3'd2,
    ST_LONG        = 3'd3,
    ST_EXTENDED    = 3'd4,
    ST_DEB_RELEASE = 3'd5
  } state_t;

  logic               active_level_r;
  logic               enable_r;
  bdpc_pkg::thr_t     debounce_r;
  bdpc_pkg::thr_t     poll_r;
  bdpc_pkg::thr_t     short_max_r;
  bdpc_pkg::thr_t     long_min_r;
  bdpc_pkg::thr_t     ext_min_r;

  state_t             state_r, state_nxt;
  logic [15:0]        wait_r, wait_nxt;
  bdpc_pkg::hold_t    hold_r, hold_nxt;
  logic               prev_r, prev_nxt;
  logic               pressed_r, pressed_nxt;
  bdpc_pkg::event_t   event_r, event_nxt;
  logic               out_valid_r;

  logic               accept;
  logic               cfg_wr;
  logic               pin_edge;
  logic               pin_active;
  logic               held;
  logic [15:0]        wait_inc;
  logic [15:0]        dwait;
  logic [15:0]        pwait;
  bdpc_pkg::hold_t    hold_inc;
  bdpc_pkg::cmp_t     hold_cmp;
  logic               ge_long;
  logic               ge_ext;
  logic               lt_short;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign cfg_wr    = psel && penable && pwrite;
  assign pready    = 1'b1;

  assign out_valid         = out_valid_r;
  assign out_event_code    = event_r;
  assign out_pressed       = pressed_r;
  assign out_machine_state = state_r;

  always_comb begin
    unique case (paddr[4:2])
      bdpc_pkg::REG_ACTIVE_LEVEL:   prdata = {31'd0, active_level_r};
      bdpc_pkg::REG_ENABLE:         prdata = {31'd0, enable_r};
      bdpc_pkg::REG_DEBOUNCE_TICKS: prdata = {16'd0, debounce_r};
      bdpc_pkg::REG_POLL_TICKS:     prdata = {16'd0, poll_r};
      bdpc_pkg::REG_SHORT_MAX:      prdata = {16'd0, short_max_r};
      bdpc_pkg::REG_LONG_MIN:       prdata = {16'd0, long_min_r};
      bdpc_pkg::REG_EXTENDED_MIN:   prdata = {16'd0, ext_min_r};
      default:                      prdata = 32'd0;
    endcase
  end

  assign pin_edge   = in_pin_level != prev_r;
  assign pin_active = in_pin_level == active_level_r;
  assign held       = (state_r == ST_PRESSED) || (state_r == ST_LONG) ||
                      (state_r == ST_EXTENDED) || (state_r == ST_DEB_RELEASE);
  assign wait_inc   = (wait_r == 16'hFFFF) ? wait_r : wait_r + 16'd1;
  assign dwait      = (debounce_r == 16'd0) ? 16'd1 : debounce_r;
  assign pwait      = (poll_r == 16'd0) ? 16'd1 : poll_r;
  assign hold_inc   = (held && (hold_r != '1)) ? hold_r + 1'b1 : hold_r;
  assign hold_cmp   = bdpc_pkg::cmp_t'(hold_inc);
  assign ge_long    = hold_cmp >= bdpc_pkg::cmp_t'(long_min_r);
  assign ge_ext     = hold_cmp >= bdpc_pkg::cmp_t'(ext_min_r);
  assign lt_short   = hold_cmp <  bdpc_pkg::cmp_t'(short_max_r);

  always_comb begin
    state_nxt   = state_r;
    wait_nxt    = wait_r;
    hold_nxt    = hold_r;
    prev_nxt    = in_pin_level;
    pressed_nxt = pressed_r;
    event_nxt   = bdpc_pkg::EV_NONE;
    if (!enable_r) begin
      state_nxt   = ST_IDLE;
      pressed_nxt = 1'b0;
      wait_nxt    = 16'd0;
      hold_nxt    = '0;
    end else begin
      hold_nxt = hold_inc;
      unique case (state_r) inside
        ST_IDLE: begin
          if (pin_edge) begin
            state_nxt = ST_DEB_PRESS;
            wait_nxt  = 16'd0;
          end
        end
        ST_DEB_PRESS, ST_DEB_RELEASE: begin
          if (pin_edge) begin
            wait_nxt = 16'd0;
          end else if (wait_inc < dwait) begin
            wait_nxt = wait_inc;
          end else begin
            wait_nxt = 16'd0;
            if (state_r == ST_DEB_PRESS) begin
              if (pin_active) begin
                pressed_nxt = 1'b1;
                hold_nxt    = '0;
                state_nxt   = ST_PRESSED;
              end else begin
                state_nxt = ST_IDLE;
              end
            end else if (!pin_active) begin
              pressed_nxt = 1'b0;
              state_nxt   = ST_IDLE;
              if (lt_short) begin
                event_nxt = bdpc_pkg::EV_SHORT;
              end else if (ge_ext) begin
                event_nxt = bdpc_pkg::EV_EXT_RELEASE;
              end else if (ge_long) begin
                event_nxt = bdpc_pkg::EV_LONG_RELEASE;
              end
            end else if (ge_ext) begin
              state_nxt = ST_EXTENDED;
            end else if (ge_long) begin
              state_nxt = ST_LONG;
            end else begin
              state_nxt = ST_PRESSED;
            end
          end
        end
        ST_PRESSED, ST_LONG, ST_EXTENDED: begin
          if (!pin_edge && (wait_inc < pwait)) begin
            wait_nxt = wait_inc;
          end else begin
            wait_nxt = 16'd0;
            if (!pin_active) begin
              state_nxt = ST_DEB_RELEASE;
            end else if ((state_r == ST_PRESSED) && ge_long) begin
              state_nxt = ST_LONG;
              event_nxt = bdpc_pkg::EV_LONG_START;
            end else if ((state_r == ST_LONG) && ge_ext) begin
              state_nxt = ST_EXTENDED;
              event_nxt = bdpc_pkg::EV_EXT_START;
            end
          end
        end
        default: begin
          state_nxt   = ST_IDLE;
          pressed_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_level_r <= 1'b0;
      enable_r       <= 1'b0;
      debounce_r     <= 16'd50;
      poll_r         <= 16'd10;
      short_max_r    <= 16'd500;
      long_min_r     <= 16'd1000;
      ext_min_r      <= 16'd5000;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        bdpc_pkg::REG_ACTIVE_LEVEL:   active_level_r <= pwdata[0];
        bdpc_pkg::REG_ENABLE:         enable_r       <= pwdata[0];
        bdpc_pkg::REG_DEBOUNCE_TICKS: debounce_r     <= pwdata[15:0];
        bdpc_pkg::REG_POLL_TICKS:     poll_r         <= pwdata[15:0];
        bdpc_pkg::REG_SHORT_MAX:      short_max_r    <= pwdata[15:0];
        bdpc_pkg::REG_LONG_MIN:       long_min_r     <= pwdata[15:0];
        bdpc_pkg::REG_EXTENDED_MIN:   ext_min_r      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wait_r      <= 16'd0;
      hold_r      <= '0;
      prev_r      <= 1'b1;
      pressed_r   <= 1'b0;
      event_r     <= bdpc_pkg::EV_NONE;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        state_r   <= state_nxt;
        wait_r    <= wait_nxt;
        hold_r    <= hold_nxt;
        prev_r    <= prev_nxt;
        pressed_r <= pressed_nxt;
        event_r   <= event_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  `BDPC_ASSERT_IMP(a_pressed_matches_state, out_valid, out_pressed == held)
  `BDPC_ASSERT_IMP(a_release_goes_idle, out_valid && ((out_event_code == bdpc_pkg::EV_SHORT) || (out_event_code == bdpc_pkg::EV_LONG_RELEASE) || (out_event_code == bdpc_pkg::EV_EXT_RELEASE)), (state_r == ST_IDLE) && !pressed_r)
  `BDPC_ASSERT_NXT(a_disabled_idles, accept && !enable_r, out_valid && (state_r == ST_IDLE) && (event_r == bdpc_pkg::EV_NONE))

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// Button debounce press classifier testbench
// Sends pin ticks over a valid/ready channel, updates the registers through
// the APB port while the block is idle, and checks every result item against
// a cycle-free software copy of the debounce and classification machine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int STALL_LIMIT = 5000;

  typedef enum logic [2:0] {
    S_IDLE        = 3'd0,
    S_DEB_PRESS   = 3'd1,
    S_PRESSED     = 3'd2,
    S_LONG        = 3'd3,
    S_EXTENDED    = 3'd4,
    S_DEB_RELEASE = 3'd5
  } btn_state_t;

  typedef struct packed {
    bdpc_pkg::event_t ev;
    logic             pressed;
    logic [2:0]       state;
  } tick_result_t;

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_ready;
  logic                           in_pin_level;
  logic                           out_valid;
  logic                           out_ready;
  logic [2:0]                     out_event_code;
  logic                           out_pressed;
  logic [2:0]                     out_machine_state;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [bdpc_pkg::ADDR_BITS-1:0] paddr;
  logic [31:0]                    pwdata;
  logic [31:0]                    prdata;
  logic                           pready;

  button_debounce_press_classifier uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_pin_level      (in_pin_level),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_event_code    (out_event_code),
    .out_pressed       (out_pressed),
    .out_machine_state (out_machine_state),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  int sender_gap_pct;
  int recv_stall_pct;
  int hold_off_left;
  int error_count;
  int ticks_sent;

  tick_result_t expected_ticks[$];

  logic        cur_active_level;
  logic        cur_enable;
  logic [15:0] cur_debounce;
  logic [15:0] cur_poll;
  logic [15:0] cur_short_max;
  logic [15:0] cur_long_min;
  logic [15:0] cur_ext_min;

  btn_state_t  st_q;
  logic [15:0] wait_cnt;
  logic [15:0] hold_cnt;
  logic        prev_pin;
  logic        pressed_q;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic tick_result_t classify_tick(input logic pin);
    logic             pin_changed;
    logic             is_active;
    logic             check_now;
    logic [15:0]      dwait;
    logic [15:0]      pwait;
    bdpc_pkg::event_t ev;
    tick_result_t     res;
    pin_changed = (pin != prev_pin);
    is_active   = (pin == cur_active_level);
    ev          = bdpc_pkg::EV_NONE;
    dwait       = (cur_debounce == 16'd0) ? 16'd1 : cur_debounce;
    pwait       = (cur_poll == 16'd0) ? 16'd1 : cur_poll;
    prev_pin    = pin;
    if (!cur_enable) begin
      st_q      = S_IDLE;
      pressed_q = 1'b0;
      wait_cnt  = 16'd0;
      hold_cnt  = 16'd0;
    end else begin
      if (st_q >= S_PRESSED && st_q <= S_DEB_RELEASE && hold_cnt != 16'hFFFF)
        hold_cnt++;
      case (st_q)
        S_IDLE: begin
          if (pin_changed) begin
            st_q     = S_DEB_PRESS;
            wait_cnt = 16'd0;
          end
        end
        S_DEB_PRESS, S_DEB_RELEASE: begin
          if (pin_changed) begin
            wait_cnt = 16'd0;
          end else begin
            if (wait_cnt != 16'hFFFF) wait_cnt++;
            if (wait_cnt >= dwait) begin
              wait_cnt = 16'd0;
              if (st_q == S_DEB_PRESS) begin
                if (is_active) begin
                  pressed_q = 1'b1;
                  hold_cnt  = 16'd0;
                  st_q      = S_PRESSED;
                end else begin
                  st_q = S_IDLE;
                end
              end else if (!is_active) begin
                pressed_q = 1'b0;
                if (hold_cnt < cur_short_max) ev = bdpc_pkg::EV_SHORT;
                else if (hold_cnt >= cur_ext_min) ev = bdpc_pkg::EV_EXT_RELEASE;
                else if (hold_cnt >= cur_long_min) ev = bdpc_pkg::EV_LONG_RELEASE;
                st_q = S_IDLE;
              end else if (hold_cnt >= cur_ext_min) begin
                st_q = S_EXTENDED;
              end else if (hold_cnt >= cur_long_min) begin
                st_q = S_LONG;
              end else begin
                st_q = S_PRESSED;
              end
            end
          end
        end
        S_PRESSED, S_LONG, S_EXTENDED: begin
          check_now = 1'b1;
          if (!pin_changed) begin
            if (wait_cnt != 16'hFFFF) wait_cnt++;
            check_now = (wait_cnt >= pwait);
          end
          if (check_now) begin
            wait_cnt = 16'd0;
            if (!is_active) begin
              st_q = S_DEB_RELEASE;
            end else if (st_q == S_PRESSED && hold_cnt >= cur_long_min) begin
              st_q = S_LONG;
              ev   = bdpc_pkg::EV_LONG_START;
            end else if (st_q == S_LONG && hold_cnt >= cur_ext_min) begin
              st_q = S_EXTENDED;
              ev   = bdpc_pkg::EV_EXT_START;
            end
          end
        end
        default: begin
          st_q      = S_IDLE;
          pressed_q = 1'b0;
        end
      endcase
    end
    res.ev      = ev;
    res.pressed = pressed_q;
    res.state   = st_q;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  task automatic send_tick(input logic pin);
    @(negedge clk);
    while (sender_gap_pct > 0 && $urandom_range(0, 99) < sender_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_pin_level <= pin;
    do @(posedge clk); while (!in_ready);
    expected_ticks.push_back(classify_tick(pin));
    ticks_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input bdpc_pkg::reg_idx_t idx, input logic [15:0] value);
    drain_results();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      bdpc_pkg::REG_ACTIVE_LEVEL:   cur_active_level = value[0];
      bdpc_pkg::REG_ENABLE:         cur_enable       = value[0];
      bdpc_pkg::REG_DEBOUNCE_TICKS: cur_debounce     = value;
      bdpc_pkg::REG_POLL_TICKS:     cur_poll         = value;
      bdpc_pkg::REG_SHORT_MAX:      cur_short_max    = value;
      bdpc_pkg::REG_LONG_MIN:       cur_long_min     = value;
      bdpc_pkg::REG_EXTENDED_MIN:   cur_ext_min      = value;
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_pattern(input logic [31:0] pins, input int count);
    for (int i = count - 1; i >= 0; i--) send_tick(pins[i]);
  endtask

  task automatic random_press();
    logic act;
    int   hold;
    act  = cur_active_level;
    repeat ($urandom_range(0, 3)) send_tick(1'($urandom_range(0, 1)));
    hold = $urandom_range(0, 28) + cur_debounce;
    for (int i = 0; i < hold; i++) begin
      if (i > cur_debounce && $urandom_range(0, 19) == 0) send_tick(!act);
      else send_tick(act);
    end
    repeat ($urandom_range(0, 3)) send_tick(1'($urandom_range(0, 1)));
    repeat (cur_debounce + 1 + $urandom_range(0, 3)) send_tick(!act);
  endtask

  task automatic random_setup();
    if ($urandom_range(0, 7) == 0) begin
      write_reg(bdpc_pkg::REG_ENABLE, 16'd0);
      repeat (4) send_tick(1'($urandom_range(0, 1)));
    end
    write_reg(bdpc_pkg::REG_ACTIVE_LEVEL, 16'($urandom_range(0, 1)));
    write_reg(bdpc_pkg::REG_DEBOUNCE_TICKS, 16'($urandom_range(0, 3)));
    write_reg(bdpc_pkg::REG_POLL_TICKS, 16'($urandom_range(0, 3)));
    write_reg(bdpc_pkg::REG_SHORT_MAX, 16'($urandom_range(0, 8)));
    write_reg(bdpc_pkg::REG_LONG_MIN, 16'($urandom_range(0, 14)));
    write_reg(bdpc_pkg::REG_EXTENDED_MIN, 16'($urandom_range(0, 22)));
    write_reg(bdpc_pkg::REG_ENABLE, 16'd1);
  endtask

  // with enable low every tick must report idle and released
  task automatic test_disabled();
    send_pattern(32'b101, 3);
  endtask

  task automatic test_press_classes();
    write_reg(bdpc_pkg::REG_ENABLE, 16'd1);
    write_reg(bdpc_pkg::REG_DEBOUNCE_TICKS, 16'd0);
    write_reg(bdpc_pkg::REG_POLL_TICKS, 16'd0);
    write_reg(bdpc_pkg::REG_SHORT_MAX, 16'd3);
    write_reg(bdpc_pkg::REG_LONG_MIN, 16'd4);
    write_reg(bdpc_pkg::REG_EXTENDED_MIN, 16'd6);
    // bounce then inactive: debounce restarts and rejects; then a short press
    send_pattern(32'b011, 3);
    send_pattern(32'b0011, 4);
    // hold between short and long limits: no event
    send_pattern(32'b00011, 5);
    // long and extended starts, a false release, then a second release still in debounce at the end
    send_pattern(32'b000000001001, 12);
  endtask

  task automatic test_config_extremes();
    write_reg(bdpc_pkg::REG_ACTIVE_LEVEL, 16'd1);
    write_reg(bdpc_pkg::REG_SHORT_MAX, 16'hFFFF);
    send_pattern(32'b101100, 6);
    send_pattern(32'b11, 2);
    write_reg(bdpc_pkg::REG_ENABLE, 16'd0);
    send_tick(1'b1);
    write_reg(bdpc_pkg::REG_ENABLE, 16'd1);
    write_reg(bdpc_pkg::REG_DEBOUNCE_TICKS, 16'hFFFF);
    write_reg(bdpc_pkg::REG_POLL_TICKS, 16'hFFFF);
    send_pattern(32'b0111, 4);
  endtask

  task automatic test_random_presses(input int count);
    int stop_at;
    int next_setup;
    stop_at    = ticks_sent + count;
    next_setup = ticks_sent;
    while (ticks_sent < stop_at) begin
      if (ticks_sent >= next_setup) begin
        random_setup();
        next_setup = ticks_sent + 150;
      end
      if ($urandom_range(0, 4) != 0) random_press();
      else repeat ($urandom_range(1, 6)) send_tick(1'($urandom_range(0, 1)));
    end
  endtask

  task automatic test_receiver_holdoff();
    random_setup();
    hold_off_left = 200;
    repeat (3) random_press();
    drain_results();
  endtask

  task automatic test_long_hold();
    logic act;
    write_reg(bdpc_pkg::REG_DEBOUNCE_TICKS, 16'd1);
    write_reg(bdpc_pkg::REG_POLL_TICKS, 16'd7);
    write_reg(bdpc_pkg::REG_SHORT_MAX, 16'd0);
    write_reg(bdpc_pkg::REG_LONG_MIN, 16'd20);
    write_reg(bdpc_pkg::REG_EXTENDED_MIN, 16'd45);
    write_reg(bdpc_pkg::REG_ENABLE, 16'd1);
    act = cur_active_level;
    repeat (3) send_tick(!act);
    repeat (60) send_tick(act);
    repeat (3) send_tick(!act);
  endtask

  always @(negedge clk) begin
    if (hold_off_left > 0) begin
      hold_off_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    tick_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_ticks.size() == 0) begin
        report_mismatch("unexpected result event_code", out_event_code, -1);
      end else begin
        want = expected_ticks.pop_front();
        if (out_event_code != want.ev)
          report_mismatch("event_code", out_event_code, want.ev);
        if (out_pressed != want.pressed)
          report_mismatch("pressed", out_pressed, want.pressed);
        if (out_machine_state != want.state)
          report_mismatch("machine_state", out_machine_state, want.state);
      end
    end
  end

  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    @(posedge rst_n);
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("button_debounce_press_classifier verification failed");
    $finish;
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_pin_level   = 1'b0;
    out_ready      = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    sender_gap_pct = 10;
    recv_stall_pct = 53;
    hold_off_left  = 0;
    error_count    = 0;
    ticks_sent     = 0;

    cur_active_level = 1'b0;
    cur_enable       = 1'b0;
    cur_debounce     = 16'd50;
    cur_poll         = 16'd10;
    cur_short_max    = 16'd500;
    cur_long_min     = 16'd1000;
    cur_ext_min      = 16'd5000;
    st_q             = S_IDLE;
    wait_cnt         = 16'd0;
    hold_cnt         = 16'd0;
    prev_pin         = 1'b1;
    pressed_q        = 1'b0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_disabled();
    test_press_classes();
    test_config_extremes();
    test_random_presses(340);

    drain_results();
    sender_gap_pct = 53;
    recv_stall_pct = 10;
    test_random_presses(340);
    test_receiver_holdoff();

    sender_gap_pct = 0;
    recv_stall_pct = 0;
    test_random_presses(340);
    test_long_hold();

    drain_results();
    repeat (4) @(posedge clk);
    if (error_count == 0) begin
      $display("button_debounce_press_classifier verification clean");
    end else begin
      $display("button_debounce_press_classifier verification failed");
    end
    $finish;
  end

endmodule
